// ===== sv/nmru_pkg.sv =====
package nmru_pkg;

  localparam int SET_IDX_W = 6;
  localparam int WAY_W     = 3;
  localparam int DRAW_W    = 3;

  typedef enum logic [1:0] {
    OP_TOUCH      = 2'd0,
    OP_FILL       = 2'd1,
    OP_INVALIDATE = 2'd2,
    OP_QUERY      = 2'd3
  } op_t;

  typedef struct packed {
    op_t                  operation;
    logic [SET_IDX_W-1:0] set_index;
    logic [WAY_W-1:0]     way;
    logic [DRAW_W-1:0]    random_draw;
  } in_t;

  typedef struct packed {
    logic [WAY_W-1:0] victim_way;
    logic             victim_was_invalid;
  } out_t;

endpackage

// ===== sv/nmru_store.sv =====
module nmru_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 11
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] ent_vld_r;
  logic [WIDTH-1:0] rd_q_r;
  logic [AW-1:0]    rd_addr_r;
  logic             fwd_vld_r;
  logic [AW-1:0]    fwd_addr_r;
  logic [WIDTH-1:0] fwd_data_r;

  // memory port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r     <= mem[rd_addr];
    rd_addr_r  <= rd_addr;
    fwd_addr_r <= wr_addr;
    fwd_data_r <= wr_data;
  end

  // per-entry written flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      fwd_vld_r <= 1'b0;
    end else begin
      fwd_vld_r <= wr_en;
      if (wr_en) begin
        ent_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // bypass the write made at the same edge as the read
  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == rd_addr_r)) begin
      rd_data = fwd_data_r;
    end else if (ent_vld_r[rd_addr_r]) begin
      rd_data = rd_q_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

// ===== sv/nmru_victim_selector.sv =====
// Not-most-recently-used replacement state for a set-associative cache.
// Each set keeps one MRU way and a valid bit per way.
// Input channel: an item (in_data) is taken at a rising edge with start high
// and busy low. busy is always low, so one item can be taken every cycle.
// Operations: touch makes a way MRU, fill marks it valid and makes it MRU,
// invalidate clears its valid bit, and a victim query returns a way.
// Only a query gives a result: the lowest invalid way of the set, or else
// the random draw clamped to WAYS-2 and stepped over the MRU way.
// Result channel: out_valid is high for one cycle with out_data; the
// receiver takes it at the end of that cycle and cannot stall it.
// Timing: a query is held in stage s1 while its set is read, and its result
// is registered into out_data; throughput is one item per cycle. The
// set state lives in a memory with a registered read; the write of the
// previous item is bypassed so back-to-back items on the same set see
// current state.
// Reset: every set reads as MRU way 0 with no valid ways right after reset,
// with no clearing pass; items in flight are dropped.
// Out-of-range set or way: nothing changes; a query on such a set answers
// way 0, not invalid.
module nmru_victim_selector #(
  parameter int SETS = 64,
  parameter int WAYS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  nmru_pkg::in_t in_data,
  output logic          out_valid,
  output nmru_pkg::out_t out_data
);

  localparam int IDX_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int MRU_W = $clog2(WAYS);
  localparam int ENT_W = WAYS + MRU_W;
  localparam int CW    = MRU_W + 3;

  logic                s1_vld_r;
  nmru_pkg::in_t       s1_item_r;
  logic                out_valid_r;
  nmru_pkg::out_t      out_data_r;
  nmru_pkg::out_t      out_data_nxt;

  logic [ENT_W-1:0]    rd_data;
  logic [MRU_W-1:0]    mru;
  logic [WAYS-1:0]     mask;
  logic                set_ok;
  logic                way_ok;
  logic [WAYS-1:0]     way_bit;
  logic [MRU_W-1:0]    mru_new;
  logic [WAYS-1:0]     mask_new;
  logic                wr_en;
  logic                found;
  logic [MRU_W-1:0]    inv_way;
  logic [CW-1:0]       draw;

  assign busy = 1'b0;

  nmru_store #(
    .DEPTH (SETS),
    .WIDTH (ENT_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (IDX_W'(in_data.set_index)),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(s1_item_r.set_index)),
    .wr_data ({mask_new, mru_new})
  );

  assign mru     = rd_data[MRU_W-1:0];
  assign mask    = rd_data[MRU_W +: WAYS];
  assign set_ok  = 32'(s1_item_r.set_index) < SETS;
  assign way_ok  = 32'(s1_item_r.way) < WAYS;
  assign way_bit = WAYS'(1) << MRU_W'(s1_item_r.way);

  // state update
  always_comb begin
    mru_new  = mru;
    mask_new = mask;
    wr_en    = 1'b0;
    unique case (s1_item_r.operation)
      nmru_pkg::OP_TOUCH: begin
        mru_new = MRU_W'(s1_item_r.way);
        wr_en   = s1_vld_r && set_ok && way_ok;
      end
      nmru_pkg::OP_FILL: begin
        mru_new  = MRU_W'(s1_item_r.way);
        mask_new = mask | way_bit;
        wr_en    = s1_vld_r && set_ok && way_ok;
      end
      nmru_pkg::OP_INVALIDATE: begin
        mask_new = mask & ~way_bit;
        wr_en    = s1_vld_r && set_ok && way_ok;
      end
      nmru_pkg::OP_QUERY: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // lowest invalid way
  always_comb begin
    found   = 1'b0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!mask[w]) begin
        found   = 1'b1;
        inv_way = MRU_W'(w);
      end
    end
  end

  // victim choice
  always_comb begin
    draw = CW'(s1_item_r.random_draw);
    if (draw > CW'(WAYS - 2)) begin
      draw = CW'(WAYS - 2);
    end
    if (draw >= CW'(mru)) begin
      draw = draw + CW'(1);
    end
    out_data_nxt = '0;
    if (set_ok) begin
      if (found) begin
        out_data_nxt.victim_way         = nmru_pkg::WAY_W'(inv_way);
        out_data_nxt.victim_was_invalid = 1'b1;
      end else begin
        out_data_nxt.victim_way         = draw[nmru_pkg::WAY_W-1:0];
        out_data_nxt.victim_was_invalid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r  <= in_data;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= start && !busy;
      out_valid_r <= s1_vld_r && (s1_item_r.operation == nmru_pkg::OP_QUERY);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import nmru_pkg::*;

  localparam int NUM_SETS   = 64;
  localparam int NUM_WAYS   = 8;
  localparam int RANDOM_ITEMS = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;

  logic busy_seen = 1'b0;

  logic [WAY_W-1:0] mru_of_set [NUM_SETS];
  logic [NUM_WAYS-1:0] valid_of_set [NUM_SETS];
  out_t pending_victims [$];

  int errors = 0;
  int mismatches = 0;
  int n_items = 0;
  int n_queries = 0;
  int n_invalid_picks = 0;
  int n_mru_skips = 0;
  int n_random = 0;
  logic [SET_IDX_W-1:0] hot_sets [4];

  nmru_victim_selector #(
    .SETS(NUM_SETS),
    .WAYS(NUM_WAYS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(negedge clk) begin
    busy_seen <= busy;
  end

  // apply one item to the predicted set state, return 1 when it yields a victim
  function automatic bit predict_victim(input in_t it, output out_t res);
    logic [2:0] draw;
    bit found;
    int s;
    int w;
    found = 1'b0;
    res = '0;
    s = int'(it.set_index);
    w = int'(it.way);
    if (it.operation == OP_QUERY) begin
      if (s < NUM_SETS) begin
        for (int i = 0; i < NUM_WAYS; i++) begin
          if (!found && !valid_of_set[s][i]) begin
            res.victim_way = i[WAY_W-1:0];
            res.victim_was_invalid = 1'b1;
            found = 1'b1;
          end
        end
        if (!found) begin
          draw = it.random_draw;
          if (draw > 3'(NUM_WAYS - 2)) draw = 3'(NUM_WAYS - 2);
          if (draw >= mru_of_set[s]) draw = draw + 3'd1;
          res.victim_way = draw;
          res.victim_was_invalid = 1'b0;
        end
      end
      return 1'b1;
    end
    if (s >= NUM_SETS || w >= NUM_WAYS) return 1'b0;
    case (it.operation)
      OP_TOUCH: mru_of_set[s] = it.way;
      OP_FILL: begin
        valid_of_set[s][w] = 1'b1;
        mru_of_set[s] = it.way;
      end
      OP_INVALIDATE: valid_of_set[s][w] = 1'b0;
      default: ;
    endcase
    return 1'b0;
  endfunction

  always @(negedge clk) begin
    out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_victims.size() == 0) begin
        errors++;
        if (mismatches < 10)
          $display("unexpected result: way %0d invalid %0b", out_data.victim_way,
                   out_data.victim_was_invalid);
        mismatches++;
      end else begin
        want = pending_victims.pop_front();
        if (out_data.victim_way !== want.victim_way ||
            out_data.victim_was_invalid !== want.victim_was_invalid) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch at %0t: victim_way exp %0d got %0d, was_invalid exp %0b got %0b",
                     $realtime, want.victim_way, out_data.victim_way,
                     want.victim_was_invalid, out_data.victim_was_invalid);
          mismatches++;
        end
      end
    end
  end

  function automatic in_t make_item(op_t op, int s, int w, int d);
    in_t it;
    it.operation = op;
    it.set_index = s[SET_IDX_W-1:0];
    it.way = w[WAY_W-1:0];
    it.random_draw = d[DRAW_W-1:0];
    return it;
  endfunction

  task automatic send_item(input in_t it);
    out_t res;
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy_seen);
    n_items++;
    if (predict_victim(it, res)) begin
      pending_victims.push_back(res);
      n_queries++;
      if (res.victim_was_invalid) n_invalid_picks++;
      else n_mru_skips++;
    end
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_gapped(input in_t it, input bit quiet);
    send_item(it);
    n_random++;
    if (!quiet) idle_cycles(random_gap());
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_victims.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // fresh sets answer way 0 as invalid; a touch of way 5 leaves way 0 the pick, and a fill of way 0 moves it on
  task automatic test_reset_state();
    send_item(make_item(OP_QUERY, 0, 7, 7));
    send_item(make_item(OP_TOUCH, 0, 5, 0));
    send_item(make_item(OP_QUERY, 0, 0, 0));
    send_item(make_item(OP_FILL, 0, 0, 3));
    send_item(make_item(OP_QUERY, 0, 7, 5));
    idle_cycles(random_gap());
  endtask

  task automatic test_full_set_draws();
    for (int w = 0; w < NUM_WAYS; w++) begin
      send_item(make_item(OP_FILL, 63, w, w));
      if (w == 3) idle_cycles(2);
    end
    send_item(make_item(OP_QUERY, 63, 0, 7));
    send_item(make_item(OP_QUERY, 63, 7, 0));
    send_item(make_item(OP_TOUCH, 63, 0, 7));
    send_item(make_item(OP_QUERY, 63, 3, 0));
    send_item(make_item(OP_QUERY, 63, 3, 7));
  endtask

  task automatic test_invalidate_mru();
    send_item(make_item(OP_INVALIDATE, 63, 0, 2));
    send_item(make_item(OP_QUERY, 63, 0, 4));
    send_item(make_item(OP_FILL, 63, 0, 0));
    send_item(make_item(OP_QUERY, 63, 1, 6));
  endtask

  function automatic logic [SET_IDX_W-1:0] pick_set();
    if ($urandom_range(0, 7) == 0)
      hot_sets[2'($urandom_range(0, 3))] = SET_IDX_W'($urandom_range(0, 63));
    return hot_sets[2'($urandom_range(0, 3))];
  endfunction

  function automatic op_t weighted_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return OP_QUERY;
    if (r < 60) return OP_TOUCH;
    if (r < 85) return OP_FILL;
    return OP_INVALIDATE;
  endfunction

  task automatic test_random_traffic();
    int s;
    int mode;
    int offset;
    int k;
    bit quiet;
    bit paused;
    paused = 1'b0;
    hot_sets[0] = 0;
    hot_sets[1] = 63;
    hot_sets[2] = SET_IDX_W'($urandom_range(0, 63));
    hot_sets[3] = SET_IDX_W'($urandom_range(0, 63));
    while (n_random < RANDOM_ITEMS) begin
      s = int'(pick_set());
      quiet = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        // fill the whole set so queries reach the non-MRU path
        offset = $urandom_range(0, NUM_WAYS - 1);
        for (int i = 0; i < NUM_WAYS; i++)
          send_gapped(make_item(OP_FILL, s, (i + offset) % NUM_WAYS,
                                $urandom_range(0, 7)), quiet);
        k = $urandom_range(2, 6);
        for (int i = 0; i < k; i++)
          send_gapped(make_item(($urandom_range(0, 2) == 0) ? OP_TOUCH : OP_QUERY, s,
                                $urandom_range(0, 7), $urandom_range(0, 7)), quiet);
      end else if (mode < 8) begin
        k = $urandom_range(4, 12);
        for (int i = 0; i < k; i++)
          send_gapped(make_item(weighted_op(), s, $urandom_range(0, 7),
                                $urandom_range(0, 7)), quiet);
      end else begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++)
          send_gapped(make_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                                $urandom_range(0, 7), $urandom_range(0, 7)), quiet);
      end
      if (!paused && n_random >= RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_SETS; i++) begin
      mru_of_set[i] = '0;
      valid_of_set[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_full_set_draws();
    test_invalidate_mru();
    wait_drained();
    test_random_traffic();
    wait_drained();
    $display("covered %0d items, %0d victim queries", n_items, n_queries);
    $display("answers: %0d lowest invalid way, %0d random way past the MRU, %0d mismatches",
             n_invalid_picks, n_mru_skips, mismatches);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/nmru_pkg.sv
sv/nmru_store.sv
sv/nmru_victim_selector.sv
bench/testbench.sv
